>>> hw/rtl/fir_lp_pkg.sv
`default_nettype none

package fir_lp_pkg;

    localparam int SAMPLE_W  = 16;
    localparam int COEF_W    = 16;
    localparam int NUM_COEFS = 8;
    localparam int COEF_IDX_W = 3;
    localparam int CFG_IDX_W = 4;
    localparam int PROD_W    = SAMPLE_W + COEF_W;
    localparam int ACC_W     = PROD_W + 4;

    localparam logic signed [COEF_W-1:0] COEF_RESET [NUM_COEFS] = '{
        -16'sd99, -16'sd362, -16'sd645, -16'sd488,
        16'sd724, 16'sd3142, 16'sd6037, 16'sd8036
    };

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_MAC,
        ST_FLUSH,
        ST_FINISH
    } state_t;

    typedef struct packed {
        logic load;
        logic rotate;
    } shift_ctrl_t;

    typedef struct packed {
        logic clear;
        logic mul_en;
        logic acc_en;
    } mac_ctrl_t;

    function automatic logic signed [SAMPLE_W-1:0] round_sat(
        input logic signed [ACC_W-1:0] acc
    );
        logic signed [ACC_W:0]        biased;
        logic signed [ACC_W-15:0]     q;
        logic signed [SAMPLE_W-1:0]   res;
        biased = {acc[ACC_W-1], acc} + (ACC_W+1)'(17'sd16384);
        q = biased[ACC_W:15];
        if (q > (ACC_W-14)'(32767))
            res = 16'sh7fff;
        else if (q < -(ACC_W-14)'(32768))
            res = 16'sh8000;
        else
            res = q[SAMPLE_W-1:0];
        return res;
    endfunction

endpackage

`default_nettype wire

>>> hw/rtl/fir_lp_cell.sv
`default_nettype none

module fir_lp_cell
    import fir_lp_pkg::*;
(
    input  wire logic                        clk,
    input  wire logic                        rst_n,
    input  wire shift_ctrl_t                 ctrl,
    input  wire logic signed [SAMPLE_W-1:0]  load_data,
    input  wire logic signed [SAMPLE_W-1:0]  ring_data,
    output logic signed [SAMPLE_W-1:0]       q
);

    logic signed [SAMPLE_W-1:0] sample_reg;
    logic signed [SAMPLE_W-1:0] sample_next;

    always_comb
    begin
        priority if (ctrl.load)
            sample_next = load_data;
        else if (ctrl.rotate)
            sample_next = ring_data;
        else
            sample_next = sample_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            sample_reg <= '0;
        else
            sample_reg <= sample_next;
    end

    assign q = sample_reg;

endmodule

`default_nettype wire

>>> hw/rtl/fir_lp_mac.sv
`default_nettype none

module fir_lp_mac
    import fir_lp_pkg::*;
(
    input  wire logic                        clk,
    input  wire mac_ctrl_t                   ctrl,
    input  wire logic signed [SAMPLE_W-1:0]  sample,
    input  wire logic signed [COEF_W-1:0]    coef,
    output logic signed [SAMPLE_W-1:0]       result
);

    logic signed [PROD_W-1:0] prod_reg;
    logic signed [ACC_W-1:0]  acc_reg;

    always_ff @(posedge clk)
    begin
        if (ctrl.clear)
        begin
            prod_reg <= '0;
            acc_reg  <= '0;
        end
        else
        begin
            if (ctrl.mul_en)
                prod_reg <= sample * coef;
            if (ctrl.acc_en)
                acc_reg <= acc_reg + ACC_W'(prod_reg);
        end
    end

    assign result = round_sat(acc_reg);

endmodule

`default_nettype wire

>>> hw/rtl/fir_lowpass_filter.sv
// One sample is filtered at a time by the single shared multiply-accumulate
// unit walking the rotating sample ring once per item; a new sample is taken
// only in the idle state, after the previous result has left the accumulator.
// A finished result waits in the output register while the next item runs.
// Reset (rst_n, asynchronous, active low) zeroes the delay line and loads
// the default coefficients.
`default_nettype none

module fir_lowpass_filter
    import fir_lp_pkg::*;
#(
    parameter int TAPS = 16
)
(
    input  wire logic                        clk,
    input  wire logic                        rst_n,
    input  wire logic                        cfg_valid,
    output logic                             cfg_ready,
    input  wire logic [CFG_IDX_W-1:0]        cfg_index,
    input  wire logic [COEF_W-1:0]           cfg_data,
    input  wire logic                        in_valid,
    output logic                             in_ready,
    input  wire logic signed [SAMPLE_W-1:0]  sample,
    output logic                             out_valid,
    input  wire logic                        out_ready,
    output logic signed [SAMPLE_W-1:0]       filtered
);

    localparam int CNT_W = $clog2(TAPS);

    logic signed [COEF_W-1:0]   coef_reg [NUM_COEFS];
    logic signed [SAMPLE_W-1:0] cell_q [TAPS];

    state_t             state_reg, state_next;
    logic [CNT_W-1:0]   cnt_reg, cnt_next;
    logic               out_valid_reg, out_valid_next;
    logic signed [SAMPLE_W-1:0] filtered_reg;

    shift_ctrl_t        shift_ctrl;
    mac_ctrl_t          mac_ctrl;
    logic               out_load;
    logic [CNT_W-1:0]   tap_idx;
    logic [CNT_W-1:0]   coef_sel;
    logic signed [COEF_W-1:0]   coef_cur;
    logic signed [SAMPLE_W-1:0] mac_result;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < NUM_COEFS; i++)
                coef_reg[i] <= COEF_RESET[i];
        end
        else if (cfg_valid && cfg_index < CFG_IDX_W'(NUM_COEFS))
        begin
            coef_reg[cfg_index[COEF_IDX_W-1:0]] <= cfg_data;
        end
    end

    // tap under the accumulator: the tail cell after cnt rotations
    assign tap_idx  = CNT_W'(TAPS - 1) - cnt_reg;
    assign coef_sel = (tap_idx < cnt_reg) ? tap_idx : cnt_reg;
    assign coef_cur = coef_reg[COEF_IDX_W'(coef_sel)];

    genvar g;
    generate
        for (g = 0; g < TAPS; g++)
        begin : g_cell
            if (g == 0)
            begin : g_head
                fir_lp_cell u_cell (
                    .clk       (clk),
                    .rst_n     (rst_n),
                    .ctrl      (shift_ctrl),
                    .load_data (sample),
                    .ring_data (cell_q[TAPS-1]),
                    .q         (cell_q[g])
                );
            end
            else
            begin : g_body
                fir_lp_cell u_cell (
                    .clk       (clk),
                    .rst_n     (rst_n),
                    .ctrl      (shift_ctrl),
                    .load_data (cell_q[g-1]),
                    .ring_data (cell_q[g-1]),
                    .q         (cell_q[g])
                );
            end
        end
    endgenerate

    fir_lp_mac u_mac (
        .clk    (clk),
        .ctrl   (mac_ctrl),
        .sample (cell_q[TAPS-1]),
        .coef   (coef_cur),
        .result (mac_result)
    );

    always_comb
    begin
        state_next        = state_reg;
        cnt_next          = cnt_reg;
        shift_ctrl        = '0;
        mac_ctrl          = '0;
        out_load          = 1'b0;
        in_ready          = 1'b0;
        unique case (state_reg)
            ST_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    shift_ctrl.load = 1'b1;
                    mac_ctrl.clear  = 1'b1;
                    cnt_next        = '0;
                    state_next      = ST_MAC;
                end
            end
            ST_MAC:
            begin
                shift_ctrl.rotate = 1'b1;
                mac_ctrl.mul_en   = 1'b1;
                mac_ctrl.acc_en   = 1'b1;
                cnt_next          = cnt_reg + 1'b1;
                if (cnt_reg == CNT_W'(TAPS - 1))
                    state_next = ST_FLUSH;
            end
            ST_FLUSH:
            begin
                mac_ctrl.acc_en = 1'b1;
                state_next      = ST_FINISH;
            end
            ST_FINISH:
            begin
                if (!out_valid_reg || out_ready)
                begin
                    out_load   = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        priority if (out_load)
            out_valid_next = 1'b1;
        else if (out_ready)
            out_valid_next = 1'b0;
        else
            out_valid_next = out_valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            cnt_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            cnt_reg       <= cnt_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (out_load)
            filtered_reg <= mac_result;
    end

    assign out_valid = out_valid_reg;
    assign filtered  = filtered_reg;

endmodule

`default_nettype wire

>>> hw/rtl/fir_lp_checker.sv
`default_nettype none

module fir_lp_checker
    import fir_lp_pkg::*;
#(
    parameter int TAPS = 16
)
(
    input wire logic                        clk,
    input wire logic                        rst_n,
    input wire logic                        in_valid,
    input wire logic                        in_ready,
    input wire logic                        out_valid,
    input wire logic                        out_ready,
    input wire logic signed [SAMPLE_W-1:0]  filtered
);

    // hold a stalled result
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(filtered))
        else $error("stalled result changed");

    // drop ready once an item is taken
    assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready |=> !in_ready)
        else $error("item taken while busy");

    assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready |-> ##(TAPS + 3) out_valid)
        else $error("result late");

    assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid) |-> !$past(in_ready))
        else $error("result appeared while idle");

endmodule

bind fir_lowpass_filter fir_lp_checker #(.TAPS(TAPS)) u_fir_lp_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .filtered  (filtered)
);

`default_nettype wire
